// ===== hw/rtl/gnp_pkg.sv =====
package gnp_pkg;

   // Sample and field widths.
   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int U_W = 16;
   localparam int OUT_W = 16;
   localparam int GAIN_W = 16;
   localparam logic [GAIN_W-1:0] NOISE_GAIN_RESET = 16'd655;

   // Sum of squares, accepted range below 2^30.
   localparam int S_W = 30;

   // Logarithm datapath.
   localparam int LOG_FRAC_BITS = 24;
   localparam int MANT_W = 31;
   localparam int SHAMT_W = 5;
   localparam int NL_W = SHAMT_W + LOG_FRAC_BITS;
   localparam int L_W = 30;
   localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

   // Square root and division datapath.
   localparam int SQRT_IN_W = 62;
   localparam int ROOT_W = SQRT_IN_W / 2;
   localparam int QUO_W = 31;
   localparam int R_W = 27;
   localparam int T_W = 27;

endpackage

// ===== hw/rtl/gnp_log.sv =====
module gnp_log #(
   parameter int TAG_W = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [gnp_pkg::S_W-1:0]     in_s,
   input  logic [TAG_W-1:0]            in_tag,
   output logic                        out_valid,
   output logic [gnp_pkg::L_W-1:0]     out_l,
   output logic [TAG_W-1:0]            out_tag
);

   localparam int NSQ = gnp_pkg::LOG_FRAC_BITS;
   localparam int LAT = NSQ + 3;
   localparam int MW = gnp_pkg::MANT_W;

   // Normalize stage: leading one of s and shift into Q1.30.
   logic [gnp_pkg::SHAMT_W-1:0] shamt_in;
   logic [MW-1:0] norm_in;
   logic [gnp_pkg::SHAMT_W-1:0] shamt0_ff;
   logic [MW-1:0] norm0_ff;

   always_comb begin
      shamt_in = gnp_pkg::SHAMT_W'(gnp_pkg::S_W);
      for (int k = 0; k < gnp_pkg::S_W; k++) begin
         if (in_s[k]) begin
            shamt_in = gnp_pkg::SHAMT_W'(gnp_pkg::S_W - k);
         end
      end
      norm_in = {1'b0, in_s} << shamt_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         shamt0_ff <= shamt_in;
         norm0_ff <= norm_in;
      end
   end

   // Squaring stages: one fraction bit of log2 per stage.
   logic [MW-1:0] m_ff [NSQ];
   logic [NSQ-1:0] frac_ff [NSQ];
   logic [gnp_pkg::SHAMT_W-1:0] shamt_ff [NSQ];

   for (genvar i = 0; i < NSQ; i++) begin : g_sq
      logic [MW-1:0] m_src;
      logic [NSQ-1:0] frac_src;
      logic [gnp_pkg::SHAMT_W-1:0] shamt_src;
      logic [2*MW-1:0] sq;
      logic [MW:0] mm;
      if (i == 0) begin : g_first
         assign m_src = norm0_ff;
         assign frac_src = '0;
         assign shamt_src = shamt0_ff;
      end else begin : g_next
         assign m_src = m_ff[i-1];
         assign frac_src = frac_ff[i-1];
         assign shamt_src = shamt_ff[i-1];
      end
      assign sq = m_src * m_src;
      assign mm = sq[2*MW-1:MW-1];
      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[i] <= mm[MW] ? mm[MW:1] : mm[MW-1:0];
            frac_ff[i] <= {frac_src[NSQ-2:0], mm[MW]};
            shamt_ff[i] <= shamt_src;
         end
      end
   end

   // Negated log2 in Q5.24, then scaled by 2 ln 2.
   logic [gnp_pkg::NL_W-1:0] nl_ff;
   logic [gnp_pkg::L_W-1:0] l_ff;
   logic [gnp_pkg::NL_W+31:0] lprod;

   assign lprod = nl_ff * gnp_pkg::LN2_Q32;

   always_ff @(posedge clock) begin
      if (en) begin
         nl_ff <= {shamt_ff[NSQ-1], {NSQ{1'b0}}} - {{gnp_pkg::SHAMT_W{1'b0}}, frac_ff[NSQ-1]};
         l_ff <= lprod[gnp_pkg::NL_W+31:31];
      end
   end

   // Valid and side data travel alongside.
   logic [LAT-1:0] valid_ff;
   logic [TAG_W-1:0] tag_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag_ff[0] <= in_tag;
         for (int k = 1; k < LAT; k++) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[LAT-1];
   assign out_l = l_ff;
   assign out_tag = tag_ff[LAT-1];

endmodule

// ===== hw/rtl/gnp_sqrt.sv =====
module gnp_sqrt #(
   parameter int IN_W = gnp_pkg::SQRT_IN_W,
   parameter int TAG_W = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [IN_W-1:0]      in_value,
   input  logic [TAG_W-1:0]     in_tag,
   output logic                 out_valid,
   output logic [IN_W/2-1:0]    out_root,
   output logic [TAG_W-1:0]     out_tag
);

   localparam int N = IN_W / 2;
   localparam int RW = N + 2;

   logic [RW-1:0] rem_ff [N];
   logic [N-1:0] root_ff [N];
   logic [IN_W-1:0] val_ff [N];
   logic [TAG_W-1:0] tag_ff [N];
   logic valid_ff [N];

   // One root bit per stage, restoring digit recurrence.
   for (genvar i = 0; i < N; i++) begin : g_stage
      logic [RW-1:0] rem_src;
      logic [RW-1:0] rem_sh;
      logic [RW-1:0] trial;
      logic [RW-1:0] rem_in;
      logic [N-1:0] root_src;
      logic [N-1:0] root_in;
      logic [IN_W-1:0] val_src;
      logic [TAG_W-1:0] tag_src;
      logic valid_src;
      if (i == 0) begin : g_first
         assign rem_src = '0;
         assign root_src = '0;
         assign val_src = in_value;
         assign tag_src = in_tag;
         assign valid_src = in_valid;
      end else begin : g_next
         assign rem_src = rem_ff[i-1];
         assign root_src = root_ff[i-1];
         assign val_src = val_ff[i-1];
         assign tag_src = tag_ff[i-1];
         assign valid_src = valid_ff[i-1];
      end
      assign rem_sh = {rem_src[RW-3:0], val_src[IN_W-1 -: 2]};
      assign trial = {root_src, 2'b01};
      always_comb begin
         if (rem_sh >= trial) begin
            rem_in = rem_sh - trial;
            root_in = {root_src[N-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            root_in = {root_src[N-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in;
            root_ff[i] <= root_in;
            val_ff[i] <= {val_src[IN_W-3:0], 2'b00};
            tag_ff[i] <= tag_src;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_src;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root = root_ff[N-1];
   assign out_tag = tag_ff[N-1];

endmodule

// ===== hw/rtl/gnp_div.sv =====
module gnp_div #(
   parameter int TAG_W = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [gnp_pkg::U_W-1:0]      in_mag,
   input  logic [gnp_pkg::ROOT_W-1:0]   in_den,
   input  logic [TAG_W-1:0]             in_tag,
   output logic                         out_valid,
   output logic [gnp_pkg::QUO_W-1:0]    out_quo,
   output logic [TAG_W-1:0]             out_tag
);

   localparam int N = gnp_pkg::QUO_W;
   localparam int DW = gnp_pkg::ROOT_W;

   logic [DW-1:0] rem_ff [N];
   logic [DW-1:0] den_ff [N];
   logic [N-1:0] quo_ff [N];
   logic [TAG_W-1:0] tag_ff [N];
   logic valid_ff [N];

   // Quotient of (mag << 46) / den, one bit per stage; the partial
   // remainder starts as mag << 15, which is always below den.
   for (genvar i = 0; i < N; i++) begin : g_stage
      logic [DW-1:0] rem_src;
      logic [DW-1:0] den_src;
      logic [N-1:0] quo_src;
      logic [TAG_W-1:0] tag_src;
      logic valid_src;
      logic [DW:0] rem_sh;
      logic [DW:0] den_x;
      if (i == 0) begin : g_first
         assign rem_src = {in_mag, {(DW - gnp_pkg::U_W){1'b0}}};
         assign den_src = in_den;
         assign quo_src = '0;
         assign tag_src = in_tag;
         assign valid_src = in_valid;
      end else begin : g_next
         assign rem_src = rem_ff[i-1];
         assign den_src = den_ff[i-1];
         assign quo_src = quo_ff[i-1];
         assign tag_src = tag_ff[i-1];
         assign valid_src = valid_ff[i-1];
      end
      assign rem_sh = {rem_src, 1'b0};
      assign den_x = {1'b0, den_src};
      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_sh >= den_x) begin
               rem_ff[i] <= DW'(rem_sh - den_x);
               quo_ff[i] <= {quo_src[N-2:0], 1'b1};
            end else begin
               rem_ff[i] <= rem_sh[DW-1:0];
               quo_ff[i] <= {quo_src[N-2:0], 1'b0};
            end
            den_ff[i] <= den_src;
            tag_ff[i] <= tag_src;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_src;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_quo = quo_ff[N-1];
   assign out_tag = tag_ff[N-1];

endmodule

// ===== hw/rtl/gaussian_noise_polar.sv =====
// Result path: stage 1, log, square roots, dividers, product, output register.
// Throughput: one candidate pair per cycle when not stalled; every unit is fully
// pipelined (log squaring, two square roots and two dividers, one stage per bit).
// A rejected pair gives no result and leaves a bubble in the pipeline.
// Synchronous reset clears all valid bits and sets the gain to 655.
module gaussian_noise_polar #(
   parameter int SAMPLE_BITS = gnp_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [gnp_pkg::U_W-1:0]     req_uniform_a,
   input  logic signed [gnp_pkg::U_W-1:0]     req_uniform_b,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [gnp_pkg::OUT_W-1:0]   rsp_noise_i,
   output logic signed [gnp_pkg::OUT_W-1:0]   rsp_noise_q,
   input  logic                               csr_wr_en,
   input  logic [gnp_pkg::GAIN_W-1:0]         csr_wr_data
);

   localparam int UW = gnp_pkg::U_W;
   localparam int DROP = (SAMPLE_BITS < UW) ? (UW - SAMPLE_BITS) : 0;
   localparam logic [UW-1:0] SAMPLE_MASK = UW'({UW{1'b1}} << DROP);
   localparam int LOG_TAG_W = 2 + 2 * UW + gnp_pkg::S_W;

   // Gain register.
   logic [gnp_pkg::GAIN_W-1:0] noise_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_gain_ff <= gnp_pkg::NOISE_GAIN_RESET;
      end else if (csr_wr_en) begin
         noise_gain_ff <= csr_wr_data;
      end
   end

   // Global advance: the whole pipeline moves unless the output is held.
   logic en;
   logic rsp_valid_ff;

   assign en = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   // Stage 1: magnitudes, sum of squares and rejection.
   logic [UW-1:0] a_masked;
   logic [UW-1:0] b_masked;
   logic na_in;
   logic nb_in;
   logic [UW-1:0] ma_in;
   logic [UW-1:0] mb_in;
   logic [2*UW-1:0] sq_a;
   logic [2*UW-1:0] sq_b;
   logic [2*UW:0] s_sum;
   logic reject;

   assign a_masked = req_uniform_a & SAMPLE_MASK;
   assign b_masked = req_uniform_b & SAMPLE_MASK;
   assign na_in = a_masked[UW-1];
   assign nb_in = b_masked[UW-1];
   assign ma_in = na_in ? UW'(~a_masked + 1'b1) : a_masked;
   assign mb_in = nb_in ? UW'(~b_masked + 1'b1) : b_masked;
   assign sq_a = ma_in * ma_in;
   assign sq_b = mb_in * mb_in;
   assign s_sum = {1'b0, sq_a} + {1'b0, sq_b};
   assign reject = (s_sum == '0) || (s_sum[2*UW:gnp_pkg::S_W] != '0);

   logic v1_ff;
   logic na1_ff;
   logic nb1_ff;
   logic [UW-1:0] ma1_ff;
   logic [UW-1:0] mb1_ff;
   logic [gnp_pkg::S_W-1:0] s1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid && !reject;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         na1_ff <= na_in;
         nb1_ff <= nb_in;
         ma1_ff <= ma_in;
         mb1_ff <= mb_in;
         s1_ff <= s_sum[gnp_pkg::S_W-1:0];
      end
   end

   // -2 ln s.
   logic log_valid;
   logic [gnp_pkg::L_W-1:0] log_l;
   logic [LOG_TAG_W-1:0] log_tag;

   gnp_log #(
      .TAG_W (LOG_TAG_W)
   ) u_log (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v1_ff),
      .in_s      (s1_ff),
      .in_tag    ({na1_ff, nb1_ff, ma1_ff, mb1_ff, s1_ff}),
      .out_valid (log_valid),
      .out_l     (log_l),
      .out_tag   (log_tag)
   );

   logic log_na;
   logic log_nb;
   logic [UW-1:0] log_ma;
   logic [UW-1:0] log_mb;
   logic [gnp_pkg::S_W-1:0] log_s;

   assign {log_na, log_nb, log_ma, log_mb, log_s} = log_tag;

   // Square roots of -2 ln s and of s, in parallel with equal latency.
   logic rt_valid;
   logic [gnp_pkg::ROOT_W-1:0] rt_root;
   logic [1:0] rt_signs;
   logic dn_valid;
   logic [gnp_pkg::ROOT_W-1:0] dn_root;
   logic [2*UW-1:0] dn_mags;

   gnp_sqrt #(
      .IN_W  (gnp_pkg::SQRT_IN_W),
      .TAG_W (2)
   ) u_sqrt_log (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (log_valid),
      .in_value  ({{(gnp_pkg::SQRT_IN_W - gnp_pkg::L_W - gnp_pkg::LOG_FRAC_BITS){1'b0}},
                   log_l, {gnp_pkg::LOG_FRAC_BITS{1'b0}}}),
      .in_tag    ({log_na, log_nb}),
      .out_valid (rt_valid),
      .out_root  (rt_root),
      .out_tag   (rt_signs)
   );

   gnp_sqrt #(
      .IN_W  (gnp_pkg::SQRT_IN_W),
      .TAG_W (2 * UW)
   ) u_sqrt_s (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (log_valid),
      .in_value  ({log_s, {(gnp_pkg::SQRT_IN_W - gnp_pkg::S_W){1'b0}}}),
      .in_tag    ({log_ma, log_mb}),
      .out_valid (dn_valid),
      .out_root  (dn_root),
      .out_tag   (dn_mags)
   );

   // Normalized magnitudes |u| / sqrt(s) in Q1.30.
   logic div_valid_a;
   logic div_valid_b;
   logic [gnp_pkg::QUO_W-1:0] quo_a;
   logic [gnp_pkg::QUO_W-1:0] quo_b;
   logic [gnp_pkg::R_W:0] div_tag_a;
   logic div_tag_b;

   gnp_div #(
      .TAG_W (gnp_pkg::R_W + 1)
   ) u_div_a (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rt_valid && dn_valid),
      .in_mag    (dn_mags[2*UW-1:UW]),
      .in_den    (dn_root),
      .in_tag    ({rt_signs[1], rt_root[gnp_pkg::R_W-1:0]}),
      .out_valid (div_valid_a),
      .out_quo   (quo_a),
      .out_tag   (div_tag_a)
   );

   gnp_div #(
      .TAG_W (1)
   ) u_div_b (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rt_valid && dn_valid),
      .in_mag    (dn_mags[UW-1:0]),
      .in_den    (dn_root),
      .in_tag    (rt_signs[0]),
      .out_valid (div_valid_b),
      .out_quo   (quo_b),
      .out_tag   (div_tag_b)
   );

   // Product stage: t = (c * r) >> 30.
   logic [gnp_pkg::QUO_W+gnp_pkg::R_W-1:0] prod_a;
   logic [gnp_pkg::QUO_W+gnp_pkg::R_W-1:0] prod_b;
   logic p1_valid_ff;
   logic [gnp_pkg::T_W-1:0] ta_ff;
   logic [gnp_pkg::T_W-1:0] tb_ff;
   logic na_p1_ff;
   logic nb_p1_ff;

   assign prod_a = quo_a * div_tag_a[gnp_pkg::R_W-1:0];
   assign prod_b = quo_b * div_tag_a[gnp_pkg::R_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= div_valid_a && div_valid_b;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ta_ff <= prod_a[gnp_pkg::T_W+29:30];
         tb_ff <= prod_b[gnp_pkg::T_W+29:30];
         na_p1_ff <= div_tag_a[gnp_pkg::R_W];
         nb_p1_ff <= div_tag_b;
      end
   end

   // Gain, rounding to Q3.12, sign and saturation.
   function automatic logic [gnp_pkg::OUT_W-1:0] scale_out(
      input logic [gnp_pkg::T_W-1:0] t,
      input logic neg,
      input logic [gnp_pkg::GAIN_W-1:0] gain
   );
      logic [gnp_pkg::T_W+gnp_pkg::GAIN_W-1:0] p;
      logic [gnp_pkg::T_W+gnp_pkg::GAIN_W:0] pr;
      logic [gnp_pkg::OUT_W-1:0] m;
      logic [gnp_pkg::OUT_W-1:0] res;
      p = gain * t;
      pr = {1'b0, p} + (gnp_pkg::T_W + gnp_pkg::GAIN_W + 1)'(1 << 27);
      m = pr[gnp_pkg::T_W+gnp_pkg::GAIN_W:28];
      if (neg) begin
         if (m > 16'd32768) begin
            m = 16'd32768;
         end
         res = ~m + 1'b1;
      end else begin
         if (m > 16'd32767) begin
            m = 16'd32767;
         end
         res = m;
      end
      return res;
   endfunction

   // Output register.
   logic [gnp_pkg::OUT_W-1:0] noise_i_ff;
   logic [gnp_pkg::OUT_W-1:0] noise_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         noise_i_ff <= scale_out(ta_ff, na_p1_ff, noise_gain_ff);
         noise_q_ff <= scale_out(tb_ff, nb_p1_ff, noise_gain_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_noise_i = noise_i_ff;
   assign rsp_noise_q = noise_q_ff;

   // A pair outside the unit disk, or at its center, never enters the pipeline.
   a_reject_drops: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && reject) |=> !v1_ff)
      else $error("rejected pair entered the pipeline");

   // A new result only appears when the last stage held a valid item.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(p1_valid_ff))
      else $error("result appeared without a valid item behind it");

   // The gain comes out of reset at its default.
   a_gain_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (noise_gain_ff == gnp_pkg::NOISE_GAIN_RESET))
      else $error("gain not at its reset value");

endmodule
